// ----- hw/rtl/bsu_pkg.sv -----
// Shared types and constants for the bracket-aware splitter unit.
// Used by bsu_front, bsu_queue, bsu_back and bracket_aware_splitter_unit.
package bsu_pkg;

    // Sizing
    localparam int STACK_DEPTH   = 16;
    localparam int LVL_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int IDX_BITS      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_BITS      = 16;
    localparam int OUT_BITS      = 16;
    localparam int CNT_BITS      = 16;
    localparam int CHAR_BITS     = 8;
    localparam int MASK_BITS     = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DELIMITER     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ESCAPE_MASK   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [CHAR_BITS-1:0] DELIM_RESET = 8'd44;
    localparam logic [MASK_BITS-1:0] MASK_RESET  = 4'hF;
    localparam logic [CNT_BITS-1:0]  LIMIT_RESET = 16'd0;

    // Escape mask bit positions
    localparam int MASK_QUOTE  = 0;
    localparam int MASK_PAREN  = 1;
    localparam int MASK_CURLY  = 2;
    localparam int MASK_SQUARE = 3;

    // Bracket bytes
    localparam logic [CHAR_BITS-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_BITS-1:0] CH_PAREN_OPEN  = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_PAREN_CLOSE = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_CURLY_OPEN  = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_CURLY_CLOSE = 8'h7D;
    localparam logic [CHAR_BITS-1:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_SQUARE_CLOSE = 8'h5D;

    // Kind of an open bracket on the stack
    typedef enum logic [1:0] {
        KIND_QUOTE  = 2'd0,
        KIND_PAREN  = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_SQUARE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] delimiter;
        logic [MASK_BITS-1:0] escape_mask;
        logic [CNT_BITS-1:0]  segment_limit;
    } cfg_t;

    // Up to two segment reports caused by one input byte
    typedef struct packed {
        logic                split_vld;
        logic                final_vld;
        logic                overflow;
        logic [POS_BITS-1:0] split_start;
        logic [POS_BITS-1:0] split_len;
        logic [POS_BITS-1:0] final_start;
        logic [POS_BITS-1:0] final_len;
    } seg_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/bsu_front.sv -----
// Front end: accepts bytes, tracks bracket nesting and positions, builds segment reports.
// Depends on bsu_pkg.
module bsu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsu_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bsu_pkg::CHAR_BITS-1:0] char_in,
    input  logic                        end_of_string,
    input  logic                        q_full,
    output logic                        q_push,
    output bsu_pkg::seg_entry_t         q_entry
);
    import bsu_pkg::*;

    kind_t                stack_mem [STACK_DEPTH];
    logic [LVL_BITS-1:0]  level_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  begin_reg;
    logic [CNT_BITS-1:0]  found_reg;
    logic                 ovf_reg;

    logic [IDX_BITS-1:0]  top_idx;
    kind_t                top_kind;
    logic                 top_vld;
    logic                 top_quote;
    logic [CNT_BITS:0]    found_inc;
    logic                 active;
    logic                 do_push;
    logic                 do_pop;
    kind_t                push_kind;
    logic                 stack_full;
    logic                 push_ok;
    logic                 ovf_next;
    logic [LVL_BITS-1:0]  level_after;
    logic                 split;
    logic [POS_BITS-1:0]  pos_inc;
    logic [POS_BITS-1:0]  final_start;
    logic                 accept;

    // Read top of stack
    assign top_idx   = IDX_BITS'(level_reg - LVL_BITS'(1));
    assign top_kind  = stack_mem[top_idx];
    assign top_vld   = (level_reg != '0);
    assign top_quote = top_vld && (top_kind == KIND_QUOTE);

    // Stop tracking once the segment cap is reached; compare one bit wider
    assign found_inc = {1'b0, found_reg} + (CNT_BITS+1)'(1);
    assign active    = (cfg.segment_limit == '0) ||
                       (found_inc < {1'b0, cfg.segment_limit});

    // Classify the byte into push, pop or nothing
    always_comb
    begin
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_kind = KIND_QUOTE;
        if (active)
        begin
            if (char_in == CH_QUOTE && cfg.escape_mask[MASK_QUOTE])
            begin
                if (top_quote)
                    do_pop = 1'b1;
                else
                begin
                    do_push   = 1'b1;
                    push_kind = KIND_QUOTE;
                end
            end
            else if (!top_quote)
            begin
                priority if (char_in == CH_PAREN_OPEN && cfg.escape_mask[MASK_PAREN])
                begin
                    do_push   = 1'b1;
                    push_kind = KIND_PAREN;
                end
                else if (char_in == CH_PAREN_CLOSE && top_vld && top_kind == KIND_PAREN)
                    do_pop = 1'b1;
                else if (char_in == CH_CURLY_OPEN && cfg.escape_mask[MASK_CURLY])
                begin
                    do_push   = 1'b1;
                    push_kind = KIND_CURLY;
                end
                else if (char_in == CH_CURLY_CLOSE && top_vld && top_kind == KIND_CURLY)
                    do_pop = 1'b1;
                else if (char_in == CH_SQUARE_OPEN && cfg.escape_mask[MASK_SQUARE])
                begin
                    do_push   = 1'b1;
                    push_kind = KIND_SQUARE;
                end
                else if (char_in == CH_SQUARE_CLOSE && top_vld && top_kind == KIND_SQUARE)
                    do_pop = 1'b1;
                else
                begin
                    do_push = 1'b0;
                end
            end
        end
    end

    // Drop pushes onto a full stack and flag it
    assign stack_full  = (level_reg == LVL_BITS'(STACK_DEPTH));
    assign push_ok     = do_push && !stack_full;
    assign ovf_next    = ovf_reg | (do_push && stack_full);
    assign level_after = push_ok ? level_reg + LVL_BITS'(1) :
                         do_pop  ? level_reg - LVL_BITS'(1) : level_reg;

    // Split at a top-level delimiter
    assign split       = active && (char_in == cfg.delimiter) && (level_after == '0);
    assign pos_inc     = pos_reg + POS_BITS'(1);
    assign final_start = split ? pos_inc : begin_reg;

    always_comb
    begin
        q_entry.split_vld   = split;
        q_entry.final_vld   = end_of_string;
        q_entry.overflow    = ovf_next;
        q_entry.split_start = begin_reg;
        q_entry.split_len   = pos_reg - begin_reg;
        q_entry.final_start = final_start;
        q_entry.final_len   = pos_inc - final_start;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (split || end_of_string);

    // Advance string state; clear it at the end of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            found_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_string)
            begin
                level_reg <= '0;
                pos_reg   <= '0;
                begin_reg <= '0;
                found_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                level_reg <= level_after;
                pos_reg   <= pos_inc;
                ovf_reg   <= ovf_next;
                if (split)
                begin
                    begin_reg <= pos_inc;
                    found_reg <= found_inc[CNT_BITS-1:0];
                end
            end
        end
    end

    // Write the bracket kind at the current level
    always_ff @(posedge clk)
    begin
        if (accept && push_ok)
            stack_mem[IDX_BITS'(level_reg)] <= push_kind;
    end

endmodule

// ----- hw/rtl/bsu_queue.sv -----
// Short queue of segment reports between front and back end.
// Depends on bsu_pkg.
module bsu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bsu_pkg::seg_entry_t push_entry,
    input  logic                pop,
    output bsu_pkg::seg_entry_t head,
    output bsu_pkg::q_status_t  status
);
    import bsu_pkg::*;

    seg_entry_t             entry_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS:0]     count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_BITS+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_BITS+1)'(1);
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/bsu_back.sv -----
// Back end: serializes queued reports onto the output stream through an output register.
// Depends on bsu_pkg.
module bsu_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bsu_pkg::seg_entry_t                 head,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2*bsu_pkg::OUT_BITS-1:0]      out_data,
    output logic                                out_last,
    output logic                                out_user
);
    import bsu_pkg::*;

    logic                   phase_reg;
    logic                   valid_reg;
    logic [2*OUT_BITS-1:0]  data_reg;
    logic                   last_reg;
    logic                   user_reg;
    logic                   sel_split;
    logic                   load;
    logic                   hold_entry;

    // Split report goes first, then the final report of the same entry
    assign sel_split  = head.split_vld && !phase_reg;
    assign load       = !q_empty && (!valid_reg || out_ready);
    assign hold_entry = sel_split && head.final_vld;
    assign q_pop      = load && !hold_entry;

    // Load the output register; drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            phase_reg <= hold_entry;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sel_split)
                data_reg <= {head.split_len[OUT_BITS-1:0], head.split_start[OUT_BITS-1:0]};
            else
                data_reg <= {head.final_len[OUT_BITS-1:0], head.final_start[OUT_BITS-1:0]};
            last_reg <= !sel_split;
            user_reg <= head.overflow;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;
    assign out_user  = user_reg;

endmodule

// ----- hw/rtl/bracket_aware_splitter_unit.sv -----
// Bracket-aware splitter unit: usage summary below.
// Top level; depends on bsu_pkg, bsu_front, bsu_queue, bsu_back.
//
// Input stream s_axis: one string byte per transaction, tlast on the last byte.
// Output stream m_axis: one segment per transaction, start and length in tdata,
// tlast on the final segment of a string, tuser set once a bracket push was
// dropped in that string. A delimiter byte at nesting level zero yields one
// segment; the last byte yields the final one, so one byte gives up to two.
// Configuration: cfg_we/cfg_index/cfg_data write delimiter (0), escape mask (1)
// and segment limit (2); write only while the unit is idle.
// Throughput: one byte per cycle while the queue is not full; the nesting stack is
// read and updated in the same cycle. A byte that yields two segments takes two
// output transactions. A segment passes through the queue and the output register.
// A four-entry queue separates the byte tracker from the output register, so
// input keeps flowing while a result waits; s_axis_tready drops when it fills.
// Reset clears string state and queue and restores the register defaults.
module bracket_aware_splitter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [bsu_pkg::CHAR_BITS-1:0]         s_axis_tdata,   // [7:0] char_in
    input  logic                                  s_axis_tlast,   // end_of_string
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [2*bsu_pkg::OUT_BITS-1:0]        m_axis_tdata,   // [15:0] seg_start,
                                                                  // [31:16] seg_length
    output logic                                  m_axis_tlast,   // final_segment
    output logic                                  m_axis_tuser,   // [0] nest_overflow
    // Configuration
    input  logic                                  cfg_we,
    input  logic [bsu_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [bsu_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import bsu_pkg::*;

    cfg_t        cfg_reg;
    logic        q_push;
    seg_entry_t  q_entry;
    logic        q_pop;
    seg_entry_t  q_head;
    q_status_t   q_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter     <= DELIM_RESET;
            cfg_reg.escape_mask   <= MASK_RESET;
            cfg_reg.segment_limit <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELIMITER:     cfg_reg.delimiter     <= cfg_data[CHAR_BITS-1:0];
                REG_ESCAPE_MASK:   cfg_reg.escape_mask   <= cfg_data[MASK_BITS-1:0];
                REG_SEGMENT_LIMIT: cfg_reg.segment_limit <= cfg_data[CNT_BITS-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    bsu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .char_in       (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .q_full        (q_status.full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    bsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    bsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_status.empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

    // Every queued entry carries at least one segment
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_entry.split_vld || q_entry.final_vld))
        else $error("queued entry without a segment");

    // The last byte of a string always queues a final segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> (q_push && q_entry.final_vld))
        else $error("string end did not queue a final segment");

    // Output only comes from queued data
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!q_status.empty))
        else $error("output valid without queued entry");

    // The queue fills only through a push
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_status.full) |-> $past(q_push))
        else $error("queue became full without a push");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bracket_aware_splitter_unit: streams byte strings in,
// predicts each segment report with an internal nesting tracker and checks m_axis.
// Depends on bsu_pkg and the splitter RTL only.
module testbench;
    import bsu_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 100;

    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } str_byte_t;

    typedef struct {
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] len;
        logic                fin;
        logic                ovf;
    } segment_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [CHAR_BITS-1:0]          s_axis_tdata  = '0;
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [2*OUT_BITS-1:0]         m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          m_axis_tuser;
    logic                          cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data      = '0;

    // Stimulus and expectation stores
    str_byte_t byte_queue [$];
    segment_t  seg_expect [$];
    bit        gaps_on    = 1'b1;
    int        err_count  = 0;
    int        cycle_count = 0;

    // Register copies used by the segment predictor
    logic [CHAR_BITS-1:0] delim_cfg = DELIM_RESET;
    logic [MASK_BITS-1:0] mask_cfg  = MASK_RESET;
    logic [CNT_BITS-1:0]  limit_cfg = LIMIT_RESET;

    // String state of the segment predictor
    kind_t                nest_stack [STACK_DEPTH];
    logic [LVL_BITS-1:0]  nest_level = '0;
    logic [POS_BITS-1:0]  byte_pos   = '0;
    logic [POS_BITS-1:0]  seg_begin  = '0;
    logic [CNT_BITS-1:0]  seg_count  = '0;
    logic                 nest_ovf   = 1'b0;

    bracket_aware_splitter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic bit top_is(input kind_t k);
        if (nest_level == 0)
            return 1'b0;
        return nest_stack[IDX_BITS'(nest_level - 1'b1)] == k;
    endfunction

    // Drop the push when the stack is full and flag it
    function automatic void push_kind(input kind_t k);
        if (nest_level >= STACK_DEPTH)
            nest_ovf = 1'b1;
        else
        begin
            nest_stack[IDX_BITS'(nest_level)] = k;
            nest_level++;
        end
    endfunction

    // Advance the nesting tracker by one byte and queue the segments it closes
    function automatic void predict_segments(input logic [CHAR_BITS-1:0] ch,
                                             input logic last);
        logic                tracking;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] seg_len;
        segment_t            seg;
        pos = byte_pos;
        tracking = (limit_cfg == '0) || (({1'b0, seg_count} + 17'd1) < {1'b0, limit_cfg});
        if (tracking)
        begin
            if (ch == CH_QUOTE && mask_cfg[MASK_QUOTE])
            begin
                if (top_is(KIND_QUOTE))
                    nest_level--;
                else
                    push_kind(KIND_QUOTE);
            end
            else if (!top_is(KIND_QUOTE))
            begin
                if (ch == CH_PAREN_OPEN && mask_cfg[MASK_PAREN])
                    push_kind(KIND_PAREN);
                else if (ch == CH_PAREN_CLOSE && top_is(KIND_PAREN))
                    nest_level--;
                else if (ch == CH_CURLY_OPEN && mask_cfg[MASK_CURLY])
                    push_kind(KIND_CURLY);
                else if (ch == CH_CURLY_CLOSE && top_is(KIND_CURLY))
                    nest_level--;
                else if (ch == CH_SQUARE_OPEN && mask_cfg[MASK_SQUARE])
                    push_kind(KIND_SQUARE);
                else if (ch == CH_SQUARE_CLOSE && top_is(KIND_SQUARE))
                    nest_level--;
            end
            // Split only at nesting level zero, after the stack update
            if (ch == delim_cfg && nest_level == 0)
            begin
                seg_len   = pos - seg_begin;
                seg.start = seg_begin;
                seg.len   = seg_len;
                seg.fin   = 1'b0;
                seg.ovf   = nest_ovf;
                seg_expect.insert(seg_expect.size(), seg);
                seg_count++;
                seg_begin = pos + 1'b1;
            end
        end
        if (last)
        begin
            seg_len   = pos + 1'b1;
            seg_len   = seg_len - seg_begin;
            seg.start = seg_begin;
            seg.len   = seg_len;
            seg.fin   = 1'b1;
            seg.ovf   = nest_ovf;
            seg_expect.insert(seg_expect.size(), seg);
            nest_level = '0;
            byte_pos   = '0;
            seg_begin  = '0;
            seg_count  = '0;
            nest_ovf   = 1'b0;
        end
        else
            byte_pos = pos + 1'b1;
    endfunction

    function automatic logic [CHAR_BITS-1:0] open_byte(input kind_t k);
        case (k)
            KIND_QUOTE:  return CH_QUOTE;
            KIND_PAREN:  return CH_PAREN_OPEN;
            KIND_CURLY:  return CH_CURLY_OPEN;
            default:     return CH_SQUARE_OPEN;
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] close_byte(input kind_t k);
        case (k)
            KIND_QUOTE:  return CH_QUOTE;
            KIND_PAREN:  return CH_PAREN_CLOSE;
            KIND_CURLY:  return CH_CURLY_CLOSE;
            default:     return CH_SQUARE_CLOSE;
        endcase
    endfunction

    function automatic void add_byte(input logic [CHAR_BITS-1:0] ch, input logic last);
        str_byte_t b;
        b.ch   = ch;
        b.last = last;
        byte_queue.insert(byte_queue.size(), b);
    endfunction

    // Queue one string of mostly balanced brackets; a deep one opens with a run
    // of 14 to 20 openers that can fill the stack. Return the number of bytes queued.
    function automatic int add_string(input int len, input bit deep, input bit cut);
        kind_t                opened [$];
        kind_t                k;
        logic [CHAR_BITS-1:0] ch;
        int                   r;
        int                   total;
        int                   lead;
        lead  = deep ? $urandom_range(14, 20) : 0;
        total = len + lead;
        for (int i = 0; i < total; i++)
        begin
            r = $urandom_range(99);
            if (i < lead)
            begin
                k  = kind_t'($urandom_range(1, 3));
                ch = open_byte(k);
                opened.insert(opened.size(), k);
            end
            else if (r < 14)
                ch = delim_cfg;
            else if (r < 28)
            begin
                k  = kind_t'($urandom_range(3));
                ch = open_byte(k);
                opened.insert(opened.size(), k);
            end
            else if (r < 42 && opened.size() != 0)
            begin
                k  = opened[opened.size() - 1];
                opened.delete(opened.size() - 1);
                ch = close_byte(k);
            end
            else if (r < 48)
                ch = close_byte(kind_t'($urandom_range(3)));
            else
                ch = 8'($urandom_range(255));
            add_byte(ch, cut ? 1'b0 : (i == total - 1));
        end
        return total;
    endfunction

    // Write one register; the unit is idle whenever this runs
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DELIMITER:     delim_cfg = val[CHAR_BITS-1:0];
            REG_ESCAPE_MASK:   mask_cfg  = val[MASK_BITS-1:0];
            REG_SEGMENT_LIMIT: limit_cfg = val[CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Hold until every byte is taken and every segment has come, then drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || s_axis_tvalid || seg_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CHAR_BITS-1:0] d, input logic [MASK_BITS-1:0] m,
                             input logic [CNT_BITS-1:0] lim, input int n_items,
                             input bit steady);
        int added;
        bit cut;
        gaps_on = !steady;
        write_reg(REG_DELIMITER, CFG_DATA_BITS'(d));
        write_reg(REG_ESCAPE_MASK, CFG_DATA_BITS'(m));
        write_reg(REG_SEGMENT_LIMIT, CFG_DATA_BITS'(lim));
        @(negedge clk);
        added = 0;
        while (added < n_items)
        begin
            // Sometimes leave the last string open across the register change
            cut = (added + 24 >= n_items) && ($urandom_range(3) == 0);
            added += add_string($urandom_range(1, 24), $urandom_range(99) < 15, cut);
            if (cut)
                break;
        end
        wait_idle();
    endtask

    // Input driver: offer the next queued byte, predict on each transaction
    always @(posedge clk)
    begin : byte_driver
        str_byte_t next_byte;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_segments(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_queue.size() != 0 && (!gaps_on || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_byte = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_byte.ch;
                    s_axis_tlast  <= next_byte.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each segment transaction with the oldest expectation
    always @(posedge clk)
    begin : seg_monitor
        segment_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (seg_expect.size() == 0)
                    report_mismatch($sformatf("unexpected segment start %0d length %0d",
                                              m_axis_tdata[OUT_BITS-1:0],
                                              m_axis_tdata[2*OUT_BITS-1:OUT_BITS]));
                else
                begin
                    want = seg_expect.pop_front();
                    if (m_axis_tdata[OUT_BITS-1:0] !== want.start ||
                        m_axis_tdata[2*OUT_BITS-1:OUT_BITS] !== want.len ||
                        m_axis_tlast !== want.fin || m_axis_tuser !== want.ovf)
                        report_mismatch($sformatf(
                            "got start %0d len %0d last %b ovf %b, want %0d %0d %b %b",
                            m_axis_tdata[OUT_BITS-1:0], m_axis_tdata[2*OUT_BITS-1:OUT_BITS],
                            m_axis_tlast, m_axis_tuser,
                            want.start, want.len, want.fin, want.ovf));
                end
            end
            m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings under the reset register values
        add_byte(8'h61, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(8'h62, 1'b1);
        add_byte(8'hFF, 1'b1);
        // delimiter inside parentheses, then delimiter as the last byte
        add_byte(CH_PAREN_OPEN, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(CH_PAREN_CLOSE, 1'b0);
        add_byte(DELIM_RESET, 1'b1);
        // quotes hide the parenthesis and the delimiter
        add_byte(CH_QUOTE, 1'b0);
        add_byte(CH_PAREN_OPEN, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(CH_QUOTE, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(8'h00, 1'b1);
        // a closer of the wrong kind does not pop
        add_byte(CH_SQUARE_OPEN, 1'b0);
        add_byte(CH_PAREN_CLOSE, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(CH_SQUARE_CLOSE, 1'b0);
        add_byte(DELIM_RESET, 1'b1);
        add_byte(CH_CURLY_OPEN, 1'b0);
        add_byte(DELIM_RESET, 1'b0);
        add_byte(CH_CURLY_CLOSE, 1'b1);
        wait_idle();

        // Random phases over several register settings
        run_phase(DELIM_RESET, MASK_RESET, LIMIT_RESET, 120, 1'b0);
        run_phase(8'h00, 4'h0, 16'd0, 100, 1'b0);
        run_phase(CH_PAREN_OPEN, MASK_RESET, 16'd0, 100, 1'b0);
        run_phase(CH_PAREN_CLOSE, MASK_RESET, 16'd3, 100, 1'b0);
        run_phase(CH_QUOTE, MASK_RESET, 16'd0, 100, 1'b0);
        run_phase(8'hFF, 4'($urandom_range(15)), 16'hFFFF, 100, 1'b0);
        run_phase(DELIM_RESET, MASK_RESET, 16'd1, 80, 1'b0);
        run_phase(DELIM_RESET, 4'h1, 16'd2, 80, 1'b0);
        run_phase(DELIM_RESET, MASK_RESET, 16'd0, 150, 1'b1);

        run_phase(8'($urandom_range(255)), 4'($urandom_range(15)),
                  16'($urandom_range(5)), 60, 1'b0);
        run_phase(DELIM_RESET, MASK_RESET, 16'($urandom_range(4)), 60, 1'b0);

        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
